@@ hdl/mfr_pkg.sv @@
`default_nettype none
package mfr_pkg;

	localparam int unsigned MAX_LEN_DEFAULT = 251;
	localparam int unsigned PADDR_W         = 3;
	localparam int unsigned PDATA_W         = 32;

	localparam logic [7:0] SYNC_VALUE  = 8'hAA;
	localparam logic [7:0] IDLE_LENGTH = 8'hFC;

	// register index taken from paddr[2]
	localparam logic REG_DEVICE_ADDRESS = 1'b0;

	typedef enum logic [1:0] {
		STATUS_ACCEPTED      = 2'd0,
		STATUS_WRONG_ADDRESS = 2'd1,
		STATUS_BAD_CHECKSUM  = 2'd2
	} frame_status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       ninth_bit;
		logic       framing_error;
		logic       overrun_error;
	} mfr_item_t;

	typedef struct packed {
		logic          valid;
		frame_status_t status;
		logic [7:0]    command;
		logic [7:0]    length;
	} mfr_result_t;

endpackage
`default_nettype wire

@@ hdl/multidrop_frame_receiver.sv @@
`default_nettype none
// Frame receiver for a nine-bit multidrop UART link.
// Input channel (in_valid/in_ready): one received byte per beat with its
// ninth bit and framing/overrun flags. A ninth-bit-clear byte starts a frame
// (armed on 0xAA without framing error); body bytes are address, command,
// length, payload and an 8-bit checksum of address through payload.
// Output channel (out_valid/out_ready): one beat per completed frame with
// status (accepted, wrong address, bad checksum), command and length.
// Bytes that complete no frame produce no output beat.
// A beat that is accepted lands in the input register, is evaluated against
// the frame state, and its result is registered on the output when the beat
// leaves the input register.
// Throughput: one byte per cycle while the input register is not held; the frame state updates with each byte.
// When out_ready is low and a result is waiting, the input register holds
// only if its own beat also completes a frame; otherwise bytes keep flowing.
// Reset returns the frame state to idle and clears the device address and both valid flags.
// device_address sits on the APB port at byte address 0.
module multidrop_frame_receiver #(
	parameter int unsigned MAX_LEN = mfr_pkg::MAX_LEN_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mfr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [mfr_pkg::PDATA_W-1:0] pwdata,
	output logic      [mfr_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  rx_byte,
	input  wire logic                        ninth_bit,
	input  wire logic                        framing_error,
	input  wire logic                        overrun_error,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       frame_status,
	output logic [7:0]                       command_code,
	output logic [7:0]                       payload_length
);
	import mfr_pkg::*;

	logic [7:0]    device_address_q;
	logic          valid_s1;
	mfr_item_t     item_s1;
	mfr_result_t   result;
	logic          advance;
	logic          out_valid_q;
	frame_status_t frame_status_q;
	logic [7:0]    command_code_q;
	logic [7:0]    payload_length_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_DEVICE_ADDRESS) begin
			device_address_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DEVICE_ADDRESS) begin
			prdata = {{(PDATA_W-8){1'b0}}, device_address_q};
		end
	end

	// hold the input beat only when its result cannot enter the output register
	assign advance  = valid_s1 && (!result.valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.rx_byte       <= rx_byte;
			item_s1.ninth_bit     <= ninth_bit;
			item_s1.framing_error <= framing_error;
			item_s1.overrun_error <= overrun_error;
		end
	end

	mfr_parser #(
		.MAX_LEN(MAX_LEN)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (valid_s1),
		.step          (advance),
		.item          (item_s1),
		.device_address(device_address_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			frame_status_q   <= result.status;
			command_code_q   <= result.command;
			payload_length_q <= result.length;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_status   = frame_status_q;
	assign command_code   = command_code_q;
	assign payload_length = payload_length_q;

endmodule
`default_nettype wire

@@ hdl/mfr_parser.sv @@
`default_nettype none
module mfr_parser #(
	parameter int unsigned MAX_LEN = mfr_pkg::MAX_LEN_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              step,
	input  wire mfr_pkg::mfr_item_t item,
	input  wire logic [7:0]        device_address,
	output mfr_pkg::mfr_result_t   result
);
	import mfr_pkg::*;

	localparam logic [7:0] MaxLenByte = 8'(MAX_LEN);

	logic       sync_seen_q,     sync_seen_d;
	logic [7:0] position_q,      position_d;
	logic [7:0] frame_length_q,  frame_length_d;
	logic [7:0] frame_address_q, frame_address_d;
	logic [7:0] frame_command_q, frame_command_d;
	logic [7:0] running_sum_q,   running_sum_d;

	logic [7:0] pos_inc;
	logic       done;

	assign pos_inc = position_q + 8'd1;

	// next frame state for the beat held in the input register
	always_comb begin
		sync_seen_d     = sync_seen_q;
		position_d      = position_q;
		frame_length_d  = frame_length_q;
		frame_address_d = frame_address_q;
		frame_command_d = frame_command_q;
		running_sum_d   = running_sum_q;
		done            = 1'b0;
		if (!item.ninth_bit && !item.framing_error) begin
			// start of frame; arm only on the sync value
			sync_seen_d     = (item.rx_byte == SYNC_VALUE);
			position_d      = '0;
			frame_length_d  = IDLE_LENGTH;
			frame_address_d = '0;
			frame_command_d = '0;
			running_sum_d   = '0;
		end else if (!item.ninth_bit || item.framing_error || item.overrun_error ||
				!sync_seen_q) begin
			sync_seen_d     = 1'b0;
			position_d      = '0;
			frame_length_d  = IDLE_LENGTH;
			frame_address_d = '0;
			frame_command_d = '0;
			running_sum_d   = '0;
		end else if ({1'b0, pos_inc} > ({1'b0, frame_length_q} + 9'd3)) begin
			// checksum beat: report and drop back to idle
			done            = 1'b1;
			sync_seen_d     = 1'b0;
			position_d      = '0;
			frame_length_d  = IDLE_LENGTH;
			frame_address_d = '0;
			frame_command_d = '0;
			running_sum_d   = '0;
		end else if (pos_inc == 8'd3 && item.rx_byte > MaxLenByte) begin
			sync_seen_d     = 1'b0;
			position_d      = '0;
			frame_length_d  = IDLE_LENGTH;
			frame_address_d = '0;
			frame_command_d = '0;
			running_sum_d   = '0;
		end else begin
			position_d    = pos_inc;
			running_sum_d = running_sum_q + item.rx_byte;
			if (pos_inc == 8'd1) begin
				frame_address_d = item.rx_byte;
			end
			if (pos_inc == 8'd2) begin
				frame_command_d = item.rx_byte;
			end
			if (pos_inc == 8'd3) begin
				frame_length_d = item.rx_byte;
			end
		end
	end

	always_comb begin
		result.valid   = item_valid && done;
		result.command = frame_command_q;
		result.length  = frame_length_q;
		if (frame_address_q != device_address) begin
			result.status = STATUS_WRONG_ADDRESS;
		end else if (running_sum_q != item.rx_byte) begin
			result.status = STATUS_BAD_CHECKSUM;
		end else begin
			result.status = STATUS_ACCEPTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_seen_q     <= 1'b0;
			position_q      <= '0;
			frame_length_q  <= IDLE_LENGTH;
			frame_address_q <= '0;
			frame_command_q <= '0;
			running_sum_q   <= '0;
		end else if (step) begin
			sync_seen_q     <= sync_seen_d;
			position_q      <= position_d;
			frame_length_q  <= frame_length_d;
			frame_address_q <= frame_address_d;
			frame_command_q <= frame_command_d;
			running_sum_q   <= running_sum_d;
		end
	end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
	import mfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [PADDR_W-1:0] DEVICE_ADDRESS_OFFSET = {REG_DEVICE_ADDRESS, 2'b00};

	typedef struct {
		frame_status_t status;
		logic [7:0]    command;
		logic [7:0]    length;
	} frame_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               ninth_bit = 1'b0;
	logic               framing_error = 1'b0;
	logic               overrun_error = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         frame_status;
	logic [7:0]         command_code;
	logic [7:0]         payload_length;

	// receiver-side frame state, mirrored from the byte stream
	logic       armed;
	logic [7:0] byte_pos;
	logic [7:0] hdr_len;
	logic [7:0] hdr_addr;
	logic [7:0] hdr_cmd;
	logic [7:0] sum_acc;
	logic [7:0] dev_addr;

	frame_report_t pending_reports[$];
	bit            failed = 1'b0;
	int            items_sent = 0;
	int            sender_idle_pct = 0;
	int            rcv_idle_pct = 0;
	int            hold_off_left = 0;
	int            idle_cycles = 0;

	always #5 clk = ~clk;

	multidrop_frame_receiver i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.ninth_bit     (ninth_bit),
		.framing_error (framing_error),
		.overrun_error (overrun_error),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_status  (frame_status),
		.command_code  (command_code),
		.payload_length(payload_length)
	);

	function automatic void reset_frame_state(input logic arm);
		armed    = arm;
		byte_pos = 8'h00;
		hdr_len  = IDLE_LENGTH;
		hdr_addr = 8'h00;
		hdr_cmd  = 8'h00;
		sum_acc  = 8'h00;
	endfunction

	function automatic void predict_byte(input mfr_item_t it);
		frame_report_t rep;
		if (!it.ninth_bit && !it.framing_error) begin
			reset_frame_state(it.rx_byte == SYNC_VALUE);
			return;
		end
		if (!it.ninth_bit || it.framing_error || it.overrun_error || !armed) begin
			reset_frame_state(1'b0);
			return;
		end
		byte_pos = byte_pos + 8'd1;
		if ({1'b0, byte_pos} > {1'b0, hdr_len} + 9'd3) begin
			if (hdr_addr != dev_addr)
				rep.status = STATUS_WRONG_ADDRESS;
			else if (sum_acc != it.rx_byte)
				rep.status = STATUS_BAD_CHECKSUM;
			else
				rep.status = STATUS_ACCEPTED;
			rep.command = hdr_cmd;
			rep.length  = hdr_len;
			pending_reports.push_back(rep);
			reset_frame_state(1'b0);
			return;
		end
		if (byte_pos == 8'd1) begin
			hdr_addr = it.rx_byte;
		end else if (byte_pos == 8'd2) begin
			hdr_cmd = it.rx_byte;
		end else if (byte_pos == 8'd3) begin
			if (it.rx_byte > MAX_LEN_DEFAULT) begin
				reset_frame_state(1'b0);
				return;
			end
			hdr_len = it.rx_byte;
		end
		sum_acc = sum_acc + it.rx_byte;
	endfunction

	function automatic mfr_item_t mk_item(input logic [7:0] b, input logic nb, fe, oe);
		mfr_item_t it;
		it.rx_byte       = b;
		it.ninth_bit     = nb;
		it.framing_error = fe;
		it.overrun_error = oe;
		return it;
	endfunction

	function automatic mfr_item_t random_noise();
		return mk_item(8'($urandom_range(255)), 1'($urandom_range(1)),
			$urandom_range(3) == 0, $urandom_range(3) == 0);
	endfunction

	// Offer one beat, with a random gap in front of it; valid stays up afterwards.
	task automatic send_byte(input mfr_item_t it);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid      <= 1'b1;
		rx_byte       <= it.rx_byte;
		ninth_bit     <= it.ninth_bit;
		framing_error <= it.framing_error;
		overrun_error <= it.overrun_error;
		do @(posedge clk); while (!in_ready);
		predict_byte(it);
		items_sent++;
	endtask

	// Sync, then address, command, length, payload and checksum; stop early at cut_at.
	task automatic send_frame(input logic [7:0] addr, cmd, len, input logic sync_oe,
		input logic [7:0] sum_xor, input int cut_at);
		logic [7:0] sum;
		logic [7:0] b;
		send_byte(mk_item(SYNC_VALUE, 1'b0, 1'b0, sync_oe));
		sum = 8'h00;
		for (int idx = 0; idx <= int'(len) + 3; idx++) begin
			if (idx == cut_at)
				break;
			if (idx == 0)
				b = addr;
			else if (idx == 1)
				b = cmd;
			else if (idx == 2)
				b = len;
			else if (idx == int'(len) + 3)
				b = sum ^ sum_xor;
			else
				b = 8'($urandom_range(255));
			sum = sum + b;
			send_byte(mk_item(b, 1'b1, 1'b0, 1'b0));
		end
	endtask

	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_device_address(input logic [7:0] value);
		logic [PDATA_W-1:0] rd;
		wait_for_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DEVICE_ADDRESS_OFFSET;
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[7:0] !== value) begin
			$error("device_address readback expected %02h got %02h", value, rd[7:0]);
			failed = 1'b1;
		end
		dev_addr = value;
	endtask

	task automatic test_directed_cases();
		sender_idle_pct = 0;
		rcv_idle_pct    = 0;
		// device address is still at its reset value
		send_frame(8'h00, 8'h00, 8'd0, 1'b0, 8'h00, -1);
		send_frame(8'h00, 8'hFF, 8'd1, 1'b1, 8'h00, -1);
		send_frame(8'hFF, 8'h5A, 8'd0, 1'b0, 8'h00, -1);
		send_frame(8'h00, 8'hA5, 8'd2, 1'b0, 8'hFF, -1);
		// wrong sync value, then a body byte that must be dropped
		send_byte(mk_item(8'h55, 1'b0, 1'b0, 1'b0));
		send_byte(mk_item(8'hFF, 1'b1, 1'b0, 1'b0));
		// sync with framing error does not arm
		send_byte(mk_item(SYNC_VALUE, 1'b0, 1'b1, 1'b1));
		send_byte(mk_item(8'h00, 1'b1, 1'b0, 1'b0));
		send_frame(8'h00, 8'h11, 8'd0, 1'b0, 8'h00, 2);
		send_byte(mk_item(8'h11, 1'b1, 1'b0, 1'b1));
		send_frame(8'h00, 8'h22, 8'd0, 1'b0, 8'h00, 1);
		send_byte(mk_item(8'h22, 1'b1, 1'b1, 1'b0));
		send_frame(8'h00, 8'h33, 8'd252, 1'b0, 8'h00, 3);
		send_byte(mk_item(8'h00, 1'b1, 1'b0, 1'b0));
		send_frame(8'h00, 8'h44, 8'd255, 1'b0, 8'h00, 3);
		send_frame(8'h00, 8'h77, 8'd0, 1'b0, 8'h00, -1);
	endtask

	task automatic test_address_register();
		logic [7:0] settings[4];
		sender_idle_pct = 20;
		rcv_idle_pct    = 57;
		settings = '{8'hFF, 8'h00, SYNC_VALUE, 8'($urandom_range(255))};
		foreach (settings[i]) begin
			write_device_address(settings[i]);
			send_frame(dev_addr, 8'($urandom_range(255)), 8'd3, 1'b0, 8'h00, -1);
			send_frame(dev_addr ^ 8'h01, 8'($urandom_range(255)), 8'd1, 1'b0, 8'h00, -1);
			send_frame(dev_addr ^ 8'h80, 8'($urandom_range(255)), 8'd0, 1'b0, 8'h00, -1);
			send_frame(dev_addr, 8'($urandom_range(255)), 8'd2, 1'b0, 8'h01, -1);
		end
	endtask

	task automatic test_output_backpressure();
		sender_idle_pct = 0;
		rcv_idle_pct    = 0;
		write_device_address(8'($urandom_range(255)));
		hold_off_left = 150;
		repeat (16)
			send_frame(dev_addr, 8'($urandom_range(255)), 8'd0, 1'b0, 8'h00, -1);
		// pause the sender until every report has drained
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		rcv_idle_pct = 50;
		repeat (8)
			send_frame(dev_addr, 8'($urandom_range(255)), 8'($urandom_range(3)), 1'b0,
				8'h00, -1);
	endtask

	task automatic run_random_phase(input int s_pct, r_pct, n_items);
		int         stop_at;
		int         r;
		logic [7:0] addr;
		logic [7:0] len;
		logic [7:0] sum_xor;
		sender_idle_pct = s_pct;
		rcv_idle_pct    = r_pct;
		write_device_address(8'($urandom_range(255)));
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			r       = $urandom_range(99);
			addr    = ($urandom_range(3) != 0) ? dev_addr : 8'($urandom_range(255));
			len     = ($urandom_range(49) == 0) ? 8'($urandom_range(64, 13))
				: 8'($urandom_range(12));
			sum_xor = ($urandom_range(5) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
			if (r < 10) begin
				send_byte(random_noise());
			end else if (r < 20) begin
				send_frame(addr, 8'($urandom_range(255)), len, 1'b0, 8'h00,
					$urandom_range(int'(len) + 3));
				send_byte(random_noise());
			end else if (r < 23) begin
				send_frame(addr, 8'($urandom_range(255)), 8'($urandom_range(255, 252)),
					1'b0, 8'h00, 3);
			end else begin
				send_frame(addr, 8'($urandom_range(255)), len, $urandom_range(7) == 0,
					sum_xor, -1);
			end
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(20, 57, 70);
		run_random_phase(57, 20, 70);
		run_random_phase(0, 0, 70);
	endtask

	task automatic test_longest_frames();
		sender_idle_pct = 0;
		rcv_idle_pct    = 20;
		send_frame(dev_addr, 8'($urandom_range(255)), 8'(MAX_LEN_DEFAULT), 1'b0, 8'h00, -1);
	endtask

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_off_left > 0) begin
			out_ready <= 1'b0;
			hold_off_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		frame_report_t exp_rep;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("frame report with none pending: status %0d command %02h length %0d",
					frame_status, command_code, payload_length);
				failed = 1'b1;
			end else begin
				exp_rep = pending_reports.pop_front();
				if (frame_status !== exp_rep.status) begin
					$error("frame_status expected %0d got %0d", exp_rep.status, frame_status);
					failed = 1'b1;
				end
				if (command_code !== exp_rep.command) begin
					$error("command_code expected %02h got %02h", exp_rep.command,
						command_code);
					failed = 1'b1;
				end
				if (payload_length !== exp_rep.length) begin
					$error("payload_length expected %0d got %0d", exp_rep.length,
						payload_length);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("multidrop_frame_receiver test failed");
			$finish;
		end
	end

	initial begin
		dev_addr = 8'h00;
		reset_frame_state(1'b0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_address_register();
		test_output_backpressure();
		test_random_traffic();
		test_longest_frames();

		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (!failed && pending_reports.size() == 0)
			$display("multidrop_frame_receiver test passed");
		else
			$display("multidrop_frame_receiver test failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ multidrop_frame_receiver.f @@
hdl/mfr_pkg.sv
hdl/mfr_parser.sv
hdl/multidrop_frame_receiver.sv
tb/tb.sv
